FILE: src/sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// condition implies consequence in the same cycle
`define SPQ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same cycle check");

// condition implies consequence in the next cycle
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle check");

`endif

FILE: src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// sizes, entry type and status codes of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH      = 16;
    localparam int PRIO_WIDTH = 16;
    localparam int TAG_WIDTH  = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct packed {
        logic [PRIO_WIDTH-1:0] prio;
        logic [TAG_WIDTH-1:0]  tag;
    } t_entry;

    // per-cycle move applied to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

FILE: src/spq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_req_if
// request channel: push or pop command with priority and tag
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic signed [spq_pkg::PRIO_WIDTH-1:0] priority_req;
    logic [spq_pkg::TAG_WIDTH-1:0]        tag;

    modport source (output valid, command, priority_req, tag, input ready);
    modport sink   (input valid, command, priority_req, tag, output ready);
endinterface

FILE: src/spq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_rsp_if
// result channel: status, popped entry, head entry and count
// ----------------------------------------------------------------------------
interface spq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            status;
    logic signed [spq_pkg::PRIO_WIDTH-1:0] popped_priority;
    logic [spq_pkg::TAG_WIDTH-1:0]         popped_tag;
    logic                                  head_valid;
    logic signed [spq_pkg::PRIO_WIDTH-1:0] head_priority;
    logic [spq_pkg::TAG_WIDTH-1:0]         head_tag;
    logic [spq_pkg::CNT_W-1:0]             entry_count;

    modport source (output valid, status, popped_priority, popped_tag, head_valid,
                    head_priority, head_tag, entry_count, input ready);
    modport sink   (input valid, status, popped_priority, popped_tag, head_valid,
                    head_priority, head_tag, entry_count, output ready);
endinterface

FILE: src/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds, takes the new entry, or shifts
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  spq_pkg::t_entry    i_new,
    input  spq_pkg::t_entry    i_left,
    input  logic               i_left_keep,
    input  spq_pkg::t_entry    i_right,
    output spq_pkg::t_entry    o_entry,
    output logic               o_keep,
    output spq_pkg::t_entry    o_next
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // stays in place on push when it ranks at or above the new entry
    assign o_keep = i_occ && ($signed(r_entry.prio) >= $signed(i_new.prio));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry = i_new;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

FILE: src/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue as a chain of sorted cells, stable for equal keys
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                                       handshake
//  i_req     in    command, priority_req, tag                    valid/ready
//  o_rsp     out   status, popped_*, head_*, entry_count          valid/ready
//
//  one request per cycle unless the response is stalled; each request gives
//  one response in the next cycle; all cells compare against the pushed
//  priority in parallel, so a push or pop updates all cells at once, for any depth
//  the response sits in an output register; a new request is taken while
//  it is empty or being drained in the same cycle
//  reset clears the entry count and the response valid; slot contents
//  are left as they are and only slots below the count are ever read
//
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
    input  logic  i_clk,
    input  logic  i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int DEPTH = spq_pkg::DEPTH;
    localparam int CNT_W = spq_pkg::CNT_W;

    // occupancy and control
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    spq_pkg::t_cell_ctl w_ctl;
    spq_pkg::t_entry    w_new;

    // cell chain wiring
    spq_pkg::t_entry w_entry [DEPTH];
    spq_pkg::t_entry w_next  [DEPTH];
    logic [DEPTH-1:0] w_keep;
    logic [DEPTH-1:0] w_occ;

    // response register
    logic            r_rsp_valid;
    spq_pkg::t_status r_status;
    spq_pkg::t_entry r_popped;
    logic            r_head_valid;
    spq_pkg::t_entry r_head;
    logic [CNT_W-1:0] r_rsp_count;

    // take a request while the response slot is free or draining
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_new.prio = i_req.priority_req;
    assign w_new.tag  = i_req.tag;

    // refused requests leave every cell untouched
    assign w_ctl.push = w_accept && (i_req.command == spq_pkg::CMD_PUSH) && !w_full;
    assign w_ctl.pop  = w_accept && (i_req.command == spq_pkg::CMD_POP) && !w_empty;

    always_comb begin
        n_count = r_count;
        if (w_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // the chain: slot 0 is the head, entries shift right on push, left on pop
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            spq_pkg::t_entry w_left;
            spq_pkg::t_entry w_right;
            logic            w_left_keep;

            assign w_occ[g] = (r_count > CNT_W'(g));

            if (g == 0) begin : g_first
                // nothing ranks ahead of the head slot
                assign w_left      = w_new;
                assign w_left_keep = 1'b1;
            end else begin : g_mid
                assign w_left      = w_entry[g-1];
                assign w_left_keep = w_keep[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                // tail slot falls out of range on pop
                assign w_right = w_entry[g];
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (w_occ[g]),
                .i_new       (w_new),
                .i_left      (w_left),
                .i_left_keep (w_left_keep),
                .i_right     (w_right),
                .o_entry     (w_entry[g]),
                .o_keep      (w_keep[g]),
                .o_next      (w_next[g])
            );
        end
    endgenerate

    // response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_accept) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    // response payload, head taken from the slot 0 value after this step
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (i_req.command == spq_pkg::CMD_PUSH) begin
                r_status <= w_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
            end else begin
                r_status <= w_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
            end
            r_popped     <= w_ctl.pop ? w_entry[0] : '0;
            r_head_valid <= (n_count != '0);
            r_head       <= (n_count != '0) ? w_next[0] : '0;
            r_rsp_count  <= n_count;
        end
    end

    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.popped_priority = r_popped.prio;
    assign o_rsp.popped_tag      = r_popped.tag;
    assign o_rsp.head_valid      = r_head_valid;
    assign o_rsp.head_priority   = r_head.prio;
    assign o_rsp.head_tag        = r_head.tag;
    assign o_rsp.entry_count     = r_rsp_count;

    // checks
    `SPQ_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))
    `SPQ_ASSERT_NEXT(a_full_push_holds, w_accept && (i_req.command == spq_pkg::CMD_PUSH) && w_full, r_count == CNT_W'(DEPTH))
    `SPQ_ASSERT_NEXT(a_pop_decrements, w_ctl.pop, r_count == $past(r_count) - CNT_W'(1))
    `SPQ_ASSERT_SAME(a_head_matches_count, r_rsp_valid, r_head_valid == (r_rsp_count != '0))

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted priority queue: a short directed table
// of pushes and pops at the priority extremes, on full and empty, and with
// equal priorities, then about 1300 random requests in push-heavy, pop-heavy
// and balanced bursts; every response is compared field by field with the
// typed-in response of its row or a behavioral copy of the list in the bench
// ----------------------------------------------------------------------------
module tb;
    import spq_pkg::*;

    // run shape
    localparam int RAND_ITEMS   = 1330;
    localparam int IDLE_PCT     = 9;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int DIR_ROWS     = 25;

    // one response of the block, in the order the channel carries it
    typedef struct packed {
        t_status                      status;
        logic signed [PRIO_WIDTH-1:0] popped_priority;
        logic [TAG_WIDTH-1:0]         popped_tag;
        logic                         head_valid;
        logic signed [PRIO_WIDTH-1:0] head_priority;
        logic [TAG_WIDTH-1:0]         head_tag;
        logic [CNT_W-1:0]             entry_count;
    } rsp_t;

    // directed row: the request plus, where it is obvious, the response typed in
    typedef struct {
        logic                         cmd;
        logic signed [PRIO_WIDTH-1:0] prio;
        logic [TAG_WIDTH-1:0]         tag;
        bit                           typed;
        rsp_t                         rsp;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // bench copy of the sorted list, slot 0 is the head
    logic signed [PRIO_WIDTH-1:0] sorted_prio [DEPTH];
    logic [TAG_WIDTH-1:0]         sorted_tag  [DEPTH];
    int                           stored_entries;

    // responses still owed by the block, oldest first
    rsp_t pending_rsp [$];

    // the request on the bus may carry a typed-in response
    bit   cur_typed;
    rsp_t cur_rsp;

    int mismatches;

    // idling control shared by both sides
    bit calm;
    int hold_asks;
    int hold_served;
    int hold_left;

    dir_row_t dir_table [DIR_ROWS];

    // ------------------------------------------------------------------------
    // clock and timeout
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // generous fixed limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor: one request applied to the bench copy of the list
    // ------------------------------------------------------------------------
    function automatic rsp_t apply_queue_op(logic cmd, logic signed [PRIO_WIDTH-1:0] prio,
                                            logic [TAG_WIDTH-1:0] tag);
        rsp_t r;
        int   pos;
        r = '0;
        r.status = ST_OK;
        if (cmd == CMD_PUSH) begin
            if (stored_entries >= DEPTH) begin
                // refused, list untouched
                r.status = ST_FULL;
            end else begin
                // new entry goes after every entry of greater or equal priority
                pos = 0;
                while (pos < stored_entries && sorted_prio[pos] >= prio)
                    pos++;
                for (int i = stored_entries; i > pos; i--) begin
                    sorted_prio[i] = sorted_prio[i-1];
                    sorted_tag[i]  = sorted_tag[i-1];
                end
                sorted_prio[pos] = prio;
                sorted_tag[pos]  = tag;
                stored_entries++;
            end
        end else begin
            if (stored_entries == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.popped_priority = sorted_prio[0];
                r.popped_tag      = sorted_tag[0];
                for (int i = 1; i < stored_entries; i++) begin
                    sorted_prio[i-1] = sorted_prio[i];
                    sorted_tag[i-1]  = sorted_tag[i];
                end
                stored_entries--;
            end
        end
        // head fields read zero once the list is empty
        if (stored_entries > 0) begin
            r.head_valid    = 1'b1;
            r.head_priority = sorted_prio[0];
            r.head_tag      = sorted_tag[0];
        end
        r.entry_count = CNT_W'(stored_entries);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // response compare, reports the first few and counts the rest
    // ------------------------------------------------------------------------
    function automatic void compare_rsp(rsp_t want, rsp_t got);
        bit bad;
        bad = (want.status !== got.status)
           || (want.popped_priority !== got.popped_priority)
           || (want.popped_tag !== got.popped_tag)
           || (want.head_valid !== got.head_valid)
           || (want.head_priority !== got.head_priority)
           || (want.head_tag !== got.head_tag)
           || (want.entry_count !== got.entry_count);
        if (bad) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch at %0t: exp st=%0d pop=%0d/%h head=%0b %0d/%h cnt=%0d",
                         $realtime, want.status, want.popped_priority, want.popped_tag,
                         want.head_valid, want.head_priority, want.head_tag,
                         want.entry_count);
                $display("                     got st=%0d pop=%0d/%h head=%0b %0d/%h cnt=%0d",
                         got.status, got.popped_priority, got.popped_tag, got.head_valid,
                         got.head_priority, got.head_tag, got.entry_count);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // monitor: both channels sampled at the rising edge
    // the response is matched before the request of the same edge is predicted,
    // so a new expectation never pairs with an older response
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        rsp_t got;
        rsp_t want;
        rsp_t predicted;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got.status          = t_status'(rsp_if.status);
                got.popped_priority = rsp_if.popped_priority;
                got.popped_tag      = rsp_if.popped_tag;
                got.head_valid      = rsp_if.head_valid;
                got.head_priority   = rsp_if.head_priority;
                got.head_tag        = rsp_if.head_tag;
                got.entry_count     = rsp_if.entry_count;
                if (pending_rsp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch at %0t: response with no request outstanding",
                                 $realtime);
                end else begin
                    want = pending_rsp.pop_front();
                    compare_rsp(want, got);
                end
            end
            if (req_if.valid && req_if.ready) begin
                // predictor always runs so the list stays in step with typed rows
                predicted = apply_queue_op(req_if.command, req_if.priority_req, req_if.tag);
                pending_rsp.push_back(cur_typed ? cur_rsp : predicted);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random back-pressure, plus a long hold-off on request
    // from the stimulus, counted here in its own cycles
    // ------------------------------------------------------------------------
    initial begin
        rsp_if.ready <= 1'b0;
        hold_served = 0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_asks != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end else if (calm) begin
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender: one request, with random idle cycles ahead of it; returns at the
    // rising edge where the request is taken
    // ------------------------------------------------------------------------
    task automatic send_req(logic cmd, logic signed [PRIO_WIDTH-1:0] prio,
                            logic [TAG_WIDTH-1:0] tag, bit typed, rsp_t rsp);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.command      <= cmd;
        req_if.priority_req <= prio;
        req_if.tag          <= tag;
        cur_typed = typed;
        cur_rsp   = rsp;
        // stay on the bus until the queue takes it, however long that is
        do
            @(posedge i_clk);
        while (!(req_if.valid && req_if.ready));
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                           push_pct;
        int                           sel;
        int                           small_p;
        logic                         cmd;
        logic signed [PRIO_WIDTH-1:0] prio;
        logic [TAG_WIDTH-1:0]         tag;

        // every input known from time zero
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.command      <= CMD_PUSH;
        req_if.priority_req <= '0;
        req_if.tag          <= '0;
        cur_typed      = 1'b0;
        cur_rsp        = '0;
        mismatches     = 0;
        stored_entries = 0;
        calm           = 1'b0;
        hold_asks      = 0;
        push_pct       = 50;

        // directed table
        // typed rows: empty pop after reset, the two extreme pushes, full push,
        // first pop of the max entry; the rest go through the predictor
        dir_table = '{
            // pop on an empty queue right after reset
            '{CMD_POP,  16'sh0000, 32'h0000_0000, 1'b1,
              '{ST_EMPTY, 16'sh0000, 32'h0, 1'b0, 16'sh0000, 32'h0, 5'd0}},
            // largest priority and all-ones tag become the head
            '{CMD_PUSH, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1,
              '{ST_OK, 16'sh0000, 32'h0, 1'b1, 16'sh7FFF, 32'hFFFF_FFFF, 5'd1}},
            // smallest priority lands behind it
            '{CMD_PUSH, 16'sh8000, 32'h0000_0000, 1'b1,
              '{ST_OK, 16'sh0000, 32'h0, 1'b1, 16'sh7FFF, 32'hFFFF_FFFF, 5'd2}},
            // two equal priorities, must leave in arrival order
            '{CMD_PUSH, 16'sh0000, 32'h5555_5555, 1'b0, '0},
            '{CMD_PUSH, 16'sh0000, 32'hAAAA_AAAA, 1'b0, '0},
            '{CMD_PUSH, 16'shFFFF, 32'h0000_0003, 1'b0, '0},
            // pop the max entry
            '{CMD_POP,  16'sh1234, 32'h0BAD_F00D, 1'b1,
              '{ST_OK, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1, 16'sh0000, 32'h5555_5555, 5'd4}},
            '{CMD_POP,  16'shFFFF, 32'hFFFF_FFFF, 1'b0, '0},
            // fill to the brim with entries below the head
            '{CMD_PUSH, 16'sh8000, 32'h0000_0007, 1'b0, '0},
            '{CMD_PUSH, 16'shFFFE, 32'h0000_0008, 1'b0, '0},
            '{CMD_PUSH, 16'shFF9C, 32'h0000_0009, 1'b0, '0},
            '{CMD_PUSH, 16'shFFFF, 32'h0000_000A, 1'b0, '0},
            '{CMD_PUSH, 16'sh8000, 32'h0000_000B, 1'b0, '0},
            '{CMD_PUSH, 16'shFFFB, 32'h0000_000C, 1'b0, '0},
            '{CMD_PUSH, 16'shFFFD, 32'h0000_000D, 1'b0, '0},
            '{CMD_PUSH, 16'shFFFF, 32'h0000_000E, 1'b0, '0},
            '{CMD_PUSH, 16'shFFF9, 32'h0000_000F, 1'b0, '0},
            '{CMD_PUSH, 16'sh8001, 32'h0000_0010, 1'b0, '0},
            '{CMD_PUSH, 16'shFFFE, 32'h0000_0011, 1'b0, '0},
            '{CMD_PUSH, 16'shFFF7, 32'h0000_0012, 1'b0, '0},
            '{CMD_PUSH, 16'shFFFC, 32'h0000_0013, 1'b0, '0},
            // push on a full queue is refused, head and count unchanged
            '{CMD_PUSH, 16'sh7FFF, 32'hDEAD_BEEF, 1'b1,
              '{ST_FULL, 16'sh0000, 32'h0, 1'b1, 16'sh0000, 32'hAAAA_AAAA, 5'd16}},
            '{CMD_POP,  16'sh0000, 32'h0000_0000, 1'b0, '0},
            '{CMD_PUSH, 16'sh7FFF, 32'h0000_0000, 1'b0, '0},
            '{CMD_POP,  16'sh8000, 32'hFFFF_FFFF, 1'b0, '0}
        };

        // synchronous reset held low at the start of the run
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[r])
            send_req(dir_table[r].cmd, dir_table[r].prio, dir_table[r].tag,
                     dir_table[r].typed, dir_table[r].rsp);

        // random part: bursts that are push-heavy, pop-heavy or balanced so the
        // list keeps running into full and empty; priorities mostly from a
        // narrow band so equal keys are common
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 64 == 0) begin
                sel = $urandom_range(2);
                push_pct = (sel == 0) ? 85 : (sel == 1) ? 15 : 50;
            end
            // long stretch with no idling on either side
            calm = (n >= 600 && n < 800);
            // receiver stalls long while requests keep coming
            if (n == 300 || n == 1000)
                hold_asks++;

            cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
            sel = $urandom_range(9);
            if (sel < 6) begin
                small_p = int'($urandom_range(8)) - 4;
                prio = small_p[PRIO_WIDTH-1:0];
            end else if (sel < 8) begin
                prio = PRIO_WIDTH'($urandom());
            end else if (sel == 8) begin
                prio = 16'sh7FFF;
            end else begin
                prio = 16'sh8000;
            end
            tag = $urandom();
            send_req(cmd, prio, tag, 1'b0, '0);
        end
        calm = 1'b0;

        @(negedge i_clk);
        req_if.valid <= 1'b0;

        // drain every owed response, then a few more cycles for strays
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sorted_priority_queue.f
+incdir+src
src/spq_pkg.sv
src/spq_req_if.sv
src/spq_rsp_if.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
tb/tb.sv
